/* hdl/ibsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ibsc_pkg;

  localparam int LANES      = 64;
  localparam int LANE_W     = 6;
  localparam int FIELD_W    = 24;
  localparam int ROW_MAX_W  = 16;
  localparam int MARKER_W   = 16;
  localparam int MC_W       = 17;
  localparam logic [MC_W-1:0] MC_RESET = 17'd65536;

  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_EXEC
  } back_state_t;

  // one classified request as it travels from the front to the back
  typedef struct packed {
    op_t                  op;
    logic [ROW_MAX_W-1:0] row;
    logic [MARKER_W-1:0]  marker;
    logic                 in_range;
    logic [LANES-1:0]     ev_present;
    logic [LANES-1:0]     ev_ibs1;
    logic [LANES-1:0]     ev_hethet;
    logic [LANES-1:0]     ev_ibs0;
  } item_t;

endpackage

`default_nettype wire

/* hdl/ibsc_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module ibsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/ibsc_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module ibsc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire ibsc_pkg::item_t push_data,
  output logic                 full,
  output logic                 head_valid,
  input  wire logic            pop,
  output ibsc_pkg::item_t      head
);

  ibsc_pkg::item_t q [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/ibsc_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module ibsc_front #(
  parameter int MAX_WORDS = 1024
) (
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                func,
  input  wire logic [9:0]                word_index,
  input  wire logic [63:0]               a_plane0,
  input  wire logic [63:0]               a_plane1,
  input  wire logic [63:0]               b_plane0,
  input  wire logic [63:0]               b_plane1,
  input  wire logic [15:0]               marker_index,
  input  wire logic [ibsc_pkg::MC_W-1:0] marker_count,
  input  wire logic                      q_full,
  input  wire logic                      back_clearing,
  output logic                           push,
  output ibsc_pkg::item_t                push_data
);

  logic [31:0] word32;
  logic [31:0] marker32;
  logic [10:0] mc_word;
  logic [63:0] lane_mask;
  logic [63:0] present;
  logic        keep;

  assign word32   = 32'(word_index);
  assign marker32 = 32'(marker_index);
  assign mc_word  = marker_count[ibsc_pkg::MC_W-1:ibsc_pkg::LANE_W];

  // lanes of this word that lie below marker_count
  always_comb begin
    if ({1'b0, word_index} < mc_word) begin
      lane_mask = '1;
    end else if ({1'b0, word_index} == mc_word) begin
      lane_mask = (64'd1 << marker_count[ibsc_pkg::LANE_W-1:0]) - 64'd1;
    end else begin
      lane_mask = '0;
    end
  end

  assign present = (a_plane0 | a_plane1) & (b_plane0 | b_plane1) & lane_mask;

  always_comb begin
    push_data            = '0;
    push_data.marker     = marker_index;
    push_data.ev_present = present;
    push_data.ev_ibs1    = present & (a_plane0 ^ b_plane0);
    push_data.ev_hethet  = ~a_plane0 & a_plane1 & ~b_plane0 & b_plane1 & lane_mask;
    push_data.ev_ibs0    = a_plane0 & b_plane0 & (a_plane1 ^ b_plane1) & lane_mask;
    keep                 = 1'b0;
    unique case (func)
      ibsc_pkg::OP_ACC: begin
        push_data.op  = ibsc_pkg::OP_ACC;
        push_data.row = ibsc_pkg::ROW_MAX_W'(word_index);
        keep          = (word32 < 32'(MAX_WORDS));
      end
      ibsc_pkg::OP_READ: begin
        push_data.op       = ibsc_pkg::OP_READ;
        push_data.row      = ibsc_pkg::ROW_MAX_W'(marker_index[15:ibsc_pkg::LANE_W]);
        push_data.in_range = (marker32 < 32'(MAX_WORDS) * 32'd64);
        keep               = 1'b1;
      end
      ibsc_pkg::OP_CLEAR: begin
        push_data.op = ibsc_pkg::OP_CLEAR;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full || back_clearing;
  // out-of-range words and the unused code are taken and dropped here
  assign push     = in_valid && !in_stall && keep;

endmodule

`default_nettype wire

/* hdl/ibsc_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module ibsc_back #(
  parameter int MAX_WORDS  = 1024,
  parameter int COUNT_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            head_valid,
  input  wire ibsc_pkg::item_t                 head,
  output logic                                 pop,
  output logic                                 clearing,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [ibsc_pkg::MARKER_W-1:0]        read_marker,
  output logic [ibsc_pkg::FIELD_W-1:0]         nonmissing_count,
  output logic [ibsc_pkg::FIELD_W-1:0]         ibs1_count,
  output logic [ibsc_pkg::FIELD_W-1:0]         hethet_count,
  output logic [ibsc_pkg::FIELD_W-1:0]         ibs0_count
);

  localparam int AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CB     = COUNT_BITS;
  localparam int LANE_B = 4 * CB;
  localparam int ROW_W  = ibsc_pkg::LANES * LANE_B;
  localparam logic [AW-1:0] LAST_ROW = AW'(MAX_WORDS - 1);
  localparam logic [CB-1:0] COUNT_MAX = '1;

  ibsc_pkg::back_state_t state;
  ibsc_pkg::back_state_t state_next;
  ibsc_pkg::item_t       cur;
  logic [AW-1:0]         clr_row;
  logic [AW-1:0]         clr_row_next;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [ROW_W-1:0]      wr_data;
  logic                  rd_en;
  logic [ROW_W-1:0]      rd_data;
  logic [ROW_W-1:0]      bumped;
  logic [LANE_B-1:0]     lane_bits;
  logic                  out_free;
  logic                  out_load;
  logic [3:0][31:0]      cnt32;

  ibsc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (head.row[AW-1:0]),
    .rd_data (rd_data)
  );

  // 64 lanes x 4 saturating counters, all independent
  always_comb begin
    logic [CB-1:0]  c;
    logic [3:0][63:0] ev;
    ev = {cur.ev_ibs0, cur.ev_hethet, cur.ev_ibs1, cur.ev_present};
    bumped = rd_data;
    for (int l = 0; l < ibsc_pkg::LANES; l++) begin
      for (int k = 0; k < 4; k++) begin
        c = rd_data[(l*4+k)*CB +: CB];
        if (ev[k][l] && (c != COUNT_MAX)) begin
          bumped[(l*4+k)*CB +: CB] = c + CB'(1);
        end
      end
    end
  end

  assign lane_bits = rd_data[cur.marker[ibsc_pkg::LANE_W-1:0] * LANE_B +: LANE_B];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cnt32[k] = cur.in_range ? 32'(lane_bits[k*CB +: CB]) : 32'd0;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign clearing = (state == ibsc_pkg::BK_CLEAR);

  always_comb begin
    state_next   = state;
    clr_row_next = clr_row;
    pop          = 1'b0;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = cur.row[AW-1:0];
    wr_data      = bumped;
    out_load     = 1'b0;
    unique case (state)
      ibsc_pkg::BK_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_row;
        wr_data      = '0;
        clr_row_next = clr_row + AW'(1);
        if (clr_row == LAST_ROW) begin
          state_next = ibsc_pkg::BK_IDLE;
        end
      end
      ibsc_pkg::BK_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head.op == ibsc_pkg::OP_CLEAR) begin
            clr_row_next = '0;
            state_next   = ibsc_pkg::BK_CLEAR;
          end else begin
            rd_en      = 1'b1;
            state_next = ibsc_pkg::BK_EXEC;
          end
        end
      end
      ibsc_pkg::BK_EXEC: begin
        if (cur.op == ibsc_pkg::OP_ACC) begin
          wr_en      = 1'b1;
          state_next = ibsc_pkg::BK_IDLE;
        end else if (out_free) begin
          // row data is held by the RAM until the result register frees up
          out_load   = 1'b1;
          state_next = ibsc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = ibsc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ibsc_pkg::BK_CLEAR;
      clr_row <= '0;
    end else begin
      state   <= state_next;
      clr_row <= clr_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_marker      <= cur.marker;
      nonmissing_count <= cnt32[0][ibsc_pkg::FIELD_W-1:0];
      ibs1_count       <= cnt32[1][ibsc_pkg::FIELD_W-1:0];
      hethet_count     <= cnt32[2][ibsc_pkg::FIELD_W-1:0];
      ibs0_count       <= cnt32[3][ibsc_pkg::FIELD_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/pair_per_marker_ibs_counter.sv */
// Per-marker pair IBS counter. Each request either accumulates one 64-marker
// genotype word of a pair (bumping four saturating counters per marker below
// marker_count), reads the four counters of one marker, or clears all
// counters. Counters live in one RAM of MAX_WORDS rows, each row holding the
// 64 lanes of one word. The front classifies a request in the cycle it is
// taken and places it in a two-entry queue; the back reads the RAM row, then
// writes back (accumulate) or loads the result (read, once the result
// register is free), then takes the next request; there is a single
// read-modify-write path through the counter RAM. A clear writes all
// MAX_WORDS rows, one row per cycle, and the same clearing pass runs after
// reset; no request is taken during either. Only reads produce a result.
`timescale 1ns / 1ps
`default_nettype none

module pair_per_marker_ibs_counter #(
  parameter int MAX_WORDS  = 1024,
  parameter int COUNT_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [9:0]  word_index,
  input  wire logic [63:0] a_plane0,
  input  wire logic [63:0] a_plane1,
  input  wire logic [63:0] b_plane0,
  input  wire logic [63:0] b_plane1,
  input  wire logic [15:0] marker_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      read_marker,
  output logic [23:0]      nonmissing_count,
  output logic [23:0]      ibs1_count,
  output logic [23:0]      hethet_count,
  output logic [23:0]      ibs0_count
);

  logic [ibsc_pkg::MC_W-1:0] marker_count;
  logic                      q_full;
  logic                      q_push;
  ibsc_pkg::item_t           q_push_data;
  logic                      q_head_valid;
  ibsc_pkg::item_t           q_head;
  logic                      q_pop;
  logic                      back_clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker_count <= ibsc_pkg::MC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      marker_count <= cfg_data;
    end
  end

  ibsc_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .word_index    (word_index),
    .a_plane0      (a_plane0),
    .a_plane1      (a_plane1),
    .b_plane0      (b_plane0),
    .b_plane1      (b_plane1),
    .marker_index  (marker_index),
    .marker_count  (marker_count),
    .q_full        (q_full),
    .back_clearing (back_clearing),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  ibsc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .head       (q_head)
  );

  ibsc_back #(
    .MAX_WORDS  (MAX_WORDS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (q_head_valid),
    .head             (q_head),
    .pop              (q_pop),
    .clearing         (back_clearing),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .read_marker      (read_marker),
    .nonmissing_count (nonmissing_count),
    .ibs1_count       (ibs1_count),
    .hethet_count     (hethet_count),
    .ibs0_count       (ibs0_count)
  );

endmodule

`default_nettype wire

/* tb/ibs_tally_checker.sv */
`timescale 1ns / 1ps

module ibs_tally_checker
  import ibsc_pkg::*;
#(
  parameter int MAX_WORDS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [16:0] cfg_data,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [9:0]  word_index,
  input  wire logic [63:0] a_plane0,
  input  wire logic [63:0] a_plane1,
  input  wire logic [63:0] b_plane0,
  input  wire logic [63:0] b_plane1,
  input  wire logic [15:0] marker_index,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [15:0] read_marker,
  input  wire logic [23:0] nonmissing_count,
  input  wire logic [23:0] ibs1_count,
  input  wire logic [23:0] hethet_count,
  input  wire logic [23:0] ibs0_count,
  output int               fail_count,
  output int               outstanding,
  output int               reads_seen
);

  localparam int DEPTH = MAX_WORDS * LANES;
  localparam logic [FIELD_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [FIELD_W-1:0] nonmissing;
    logic [FIELD_W-1:0] ibs1;
    logic [FIELD_W-1:0] hethet;
    logic [FIELD_W-1:0] ibs0;
  } tally_t;

  typedef struct packed {
    logic [MARKER_W-1:0] marker;
    tally_t              counts;
  } read_rec_t;

  tally_t          tallies[int];   // absent entry means all four counts zero
  read_rec_t       pending_reads[$];
  logic [MC_W-1:0] marker_limit = MC_RESET;
  int              mismatches = 0;
  int              results_in = 0;
  int              pending_n = 0;

  assign fail_count  = mismatches;
  assign outstanding = pending_n;
  assign reads_seen  = results_in;

  function automatic logic [FIELD_W-1:0] sat_inc(logic [FIELD_W-1:0] v, logic hit);
    return (hit && v != COUNT_MAX) ? v + 1'b1 : v;
  endfunction

  task automatic report(string what, longint unsigned want, longint unsigned got);
    mismatches++;
    $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  task automatic accumulate_pair(logic [9:0] word, logic [63:0] a0, logic [63:0] a1,
                                 logic [63:0] b0, logic [63:0] b1);
    logic [63:0] present;
    logic [63:0] ibs1;
    logic [63:0] hethet;
    logic [63:0] ibs0;
    int          m;
    tally_t      t;
    if (word >= MAX_WORDS) return;
    present = (a0 | a1) & (b0 | b1);
    ibs1    = present & (a0 ^ b0);
    hethet  = ~a0 & a1 & ~b0 & b1;
    ibs0    = a0 & b0 & (a1 ^ b1);
    for (int lane = 0; lane < LANES; lane++) begin
      m = int'(word) * LANES + lane;
      if (m >= marker_limit || m >= DEPTH) continue;
      t = tallies.exists(m) ? tallies[m] : '0;
      t.nonmissing = sat_inc(t.nonmissing, present[lane]);
      t.ibs1       = sat_inc(t.ibs1, ibs1[lane]);
      t.hethet     = sat_inc(t.hethet, hethet[lane]);
      t.ibs0       = sat_inc(t.ibs0, ibs0[lane]);
      tallies[m] = t;
    end
  endtask

  always @(posedge clk) begin : watch
    read_rec_t want;
    tally_t    t;
    if (rst) begin
      marker_limit = MC_RESET;
      tallies.delete();
      pending_reads.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        marker_limit = cfg_data;

      if (out_valid && !out_stall) begin
        results_in++;
        if (pending_reads.size() == 0) begin
          report("unrequested result, read_marker", 0, read_marker);
        end else begin
          want = pending_reads.pop_front();
          if (read_marker !== want.marker)
            report("read_marker", want.marker, read_marker);
          if (nonmissing_count !== want.counts.nonmissing)
            report("nonmissing_count", want.counts.nonmissing, nonmissing_count);
          if (ibs1_count !== want.counts.ibs1)
            report("ibs1_count", want.counts.ibs1, ibs1_count);
          if (hethet_count !== want.counts.hethet)
            report("hethet_count", want.counts.hethet, hethet_count);
          if (ibs0_count !== want.counts.ibs0)
            report("ibs0_count", want.counts.ibs0, ibs0_count);
        end
      end

      if (in_valid && !in_stall) begin
        case (func)
          OP_ACC: accumulate_pair(word_index, a_plane0, a_plane1, b_plane0, b_plane1);
          OP_READ: begin
            t = (marker_index < DEPTH && tallies.exists(int'(marker_index))) ?
                tallies[int'(marker_index)] : '0;
            pending_reads.push_back({marker_index, t});
          end
          OP_CLEAR: tallies.delete();
          default: ;  // unused code, dropped by the block
        endcase
      end
    end
    pending_n <= pending_reads.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import ibsc_pkg::*;

  localparam int MAX_WORDS    = 1024;
  // two clears can sit back to back in the block, each sweeping every row
  localparam int DRAIN_CYCLES = 2 * MAX_WORDS + 128;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 500000;
  localparam int RANDOM_PER_PHASE = 55;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [16:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  func = OP_ACC;
  logic [9:0]  word_index = '0;
  logic [63:0] a_plane0 = '0;
  logic [63:0] a_plane1 = '0;
  logic [63:0] b_plane0 = '0;
  logic [63:0] b_plane1 = '0;
  logic [15:0] marker_index = '0;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] read_marker;
  logic [23:0] nonmissing_count;
  logic [23:0] ibs1_count;
  logic [23:0] hethet_count;
  logic [23:0] ibs0_count;

  int fail_count;
  int outstanding;
  int reads_seen;

  int  cycle_cnt = 0;
  int  n_acc = 0;
  int  n_read = 0;
  int  n_clear = 0;
  int  n_unused = 0;
  int  n_limits = 1;
  bit  no_gaps = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_on = 1'b0;
  logic [9:0] boundary_word = 10'd1023;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  pair_per_marker_ibs_counter #(
    .MAX_WORDS (MAX_WORDS),
    .COUNT_BITS(FIELD_W)
  ) dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_stall, .func, .word_index,
    .a_plane0, .a_plane1, .b_plane0, .b_plane1, .marker_index,
    .out_valid, .out_stall, .read_marker,
    .nonmissing_count, .ibs1_count, .hethet_count, .ibs0_count
  );

  ibs_tally_checker #(.MAX_WORDS(MAX_WORDS)) tally_chk (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_stall, .func, .word_index,
    .a_plane0, .a_plane1, .b_plane0, .b_plane1, .marker_index,
    .out_valid, .out_stall, .read_marker,
    .nonmissing_count, .ibs1_count, .hethet_count, .ibs0_count,
    .fail_count, .outstanding, .reads_seen
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_cnt, outstanding);
      $display("FAIL pair_per_marker_ibs_counter");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // lane l pairs genotype code l[1:0] with code l[3:2]: all 16 combinations
  function automatic void genotype_grid(output logic [63:0] a0, output logic [63:0] a1,
                                         output logic [63:0] b0, output logic [63:0] b1);
    for (int lane = 0; lane < 64; lane++) begin
      a0[lane] = lane[1];
      a1[lane] = lane[0];
      b0[lane] = lane[3];
      b1[lane] = lane[2];
    end
  endfunction

  // receiver: free runs, short and long stalls, and one requested long hold-off
  initial begin : out_side
    int len;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold_on  = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end else if ($urandom_range(99, 0) < 60) begin
        len = ($urandom_range(7, 0) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
        out_stall <= 1'b0;
        repeat (len) @(posedge clk);
      end else begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
    end
  end

  task automatic send(logic [1:0] f, logic [9:0] w, logic [63:0] a0, logic [63:0] a1,
                      logic [63:0] b0, logic [63:0] b1, logic [15:0] m);
    int gap;
    in_valid     <= 1'b1;
    func         <= f;
    word_index   <= w;
    a_plane0     <= a0;
    a_plane1     <= a1;
    b_plane0     <= b0;
    b_plane1     <= b1;
    marker_index <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (f)
      OP_ACC:   n_acc++;
      OP_READ:  n_read++;
      OP_CLEAR: n_clear++;
      default:  n_unused++;
    endcase
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic acc_pair(logic [9:0] w, logic [63:0] a0, logic [63:0] a1,
                          logic [63:0] b0, logic [63:0] b1);
    send(OP_ACC, w, a0, a1, b0, b1, 16'($urandom));
  endtask

  task automatic acc_grid(logic [9:0] w);
    logic [63:0] g0, g1, g2, g3;
    genotype_grid(g0, g1, g2, g3);
    acc_pair(w, g0, g1, g2, g3);
  endtask

  task automatic read_counts(logic [15:0] m);
    send(OP_READ, 10'($urandom), rand_word(), rand_word(), rand_word(), rand_word(), m);
  endtask

  function automatic logic [9:0] hot_word();
    case ($urandom_range(4, 0))
      0: return 10'd0;
      1: return 10'd1;
      2: return 10'd2;
      3: return 10'd1023;
      default: return boundary_word;
    endcase
  endfunction

  task automatic random_request();
    int          r;
    logic [63:0] g0, g1, g2, g3;
    r = $urandom_range(99, 0);
    if (r < 2) begin
      send(FUNC_UNUSED, 10'($urandom), rand_word(), rand_word(), rand_word(), rand_word(),
           16'($urandom));
    end else if (r < 4) begin
      send(OP_CLEAR, 10'($urandom), rand_word(), rand_word(), rand_word(), rand_word(),
           16'($urandom));
    end else if (r < 42) begin
      if ($urandom_range(99, 0) < 80)
        read_counts({hot_word(), 6'($urandom_range(63, 0))});
      else
        read_counts(16'($urandom));
    end else begin
      if ($urandom_range(99, 0) < 20) begin
        genotype_grid(g0, g1, g2, g3);
      end else begin
        g0 = rand_word();
        g1 = rand_word();
        g2 = rand_word();
        g3 = rand_word();
      end
      acc_pair(($urandom_range(99, 0) < 80) ? hot_word() : 10'($urandom), g0, g1, g2, g3);
    end
  endtask

  task automatic write_limit(logic [16:0] v);
    in_valid <= 1'b0;
    // let the checker's count take in the request accepted at this edge
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_limits++;
  endtask

  initial begin : stimulus
    logic [16:0] plan [6];
    logic [16:0] limit;
    plan = '{17'd1, 17'd70, 17'd65535, 17'($urandom_range(65536, 1)), 17'd65536, 17'd128};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed requests at the reset marker_count
    read_counts(16'd0);
    read_counts(16'd65535);
    acc_grid(10'd0);
    acc_pair(10'd0, '1, '1, '1, '1);
    acc_pair(10'd0, '0, '0, '0, '0);
    acc_grid(10'd1023);
    acc_pair(10'd1023, '1, '0, '1, '1);  // opposite homozygotes in every lane
    acc_pair(10'd682, rand_word(), rand_word(), rand_word(), rand_word());
    acc_pair(10'd341, rand_word(), rand_word(), rand_word(), rand_word());
    send(FUNC_UNUSED, 10'd1023, '1, '1, '1, '1, 16'hFFFF);
    read_counts(16'd0);
    read_counts(16'd1);
    read_counts(16'd15);
    read_counts(16'd63);
    read_counts(16'd65535);
    read_counts(16'd65472);
    read_counts(16'(682 * 64 + 21));
    send(OP_CLEAR, '0, '0, '0, '0, '0, '0);
    read_counts(16'd0);
    read_counts(16'd65535);
    acc_grid(10'd0);
    read_counts(16'd5);

    for (int p = 0; p <= 6; p++) begin
      if (p > 0) write_limit(plan[p-1]);
      limit = (p > 0) ? plan[p-1] : MC_RESET;
      boundary_word = 10'((limit - 1) >> 6);
      acc_grid(boundary_word);
      acc_grid(10'd0);
      read_counts(16'(limit - 1));
      if (limit < MC_RESET) read_counts(16'(limit));

      // output held off while reads keep coming, so the queue backs up
      if (p == 5) begin
        hold_req = 1'b1;
        while (!hold_on) @(posedge clk);
        no_gaps = 1'b1;
        repeat (30) read_counts({hot_word(), 6'($urandom_range(63, 0))});
      end

      no_gaps = (p == 2);
      repeat (RANDOM_PER_PHASE) random_request();
      no_gaps = 1'b0;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d accumulates, %0d reads, %0d clears, %0d unused-code requests",
             n_acc, n_read, n_clear, n_unused);
    $display("Checked %0d read results over %0d marker_count settings, with output hold-off",
             reads_seen, n_limits);
    if (outstanding != 0)
      $display("%0d expected read results never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS pair_per_marker_ibs_counter");
    end else begin
      $display("FAIL pair_per_marker_ibs_counter");
    end
    $finish;
  end

endmodule
